// File: hw/rtl/press_hold_tap_detector_defines.svh
// Assertion macros shared by the press/hold/tap detector RTL.
`ifndef PRESS_HOLD_TAP_DETECTOR_DEFINES_SVH
`define PRESS_HOLD_TAP_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PHT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pht assertion failed");

// Next-cycle implication, disabled during reset.
`define PHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pht assertion failed");

`endif

// File: hw/rtl/pht_pkg.sv
// Package: codes, widths and shared types of the press/hold/tap detector.
`default_nettype none
package pht_pkg;

   localparam int DEF_LEVEL_WIDTH = 16;
   localparam int DEF_TIME_WIDTH  = 32;

   localparam int MODE_WIDTH     = 2;
   localparam int PHASE_WIDTH    = 2;
   localparam int DURATION_WIDTH = 32;
   localparam int ELAPSED_WIDTH  = 16;
   localparam int HELD_WIDTH     = 32;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [PHASE_WIDTH-1:0] PH_WAITING   = 2'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_STARTED   = 2'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_PERFORMED = 2'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_CANCELED  = 2'd3;

   localparam logic [MODE_WIDTH-1:0] MODE_PRESS = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_HOLD  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_TAP   = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_NONE  = 2'd3;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_MODE      = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_DURATION  = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_THRESHOLD = 2'd2;

   typedef struct packed {
      logic started;
      logic performed;
      logic canceled;
   } pht_event_type;

endpackage
`default_nettype wire

// File: hw/rtl/pht_step.sv
// Next-state and event logic for one tick of the press/hold/tap detector.
`default_nettype none
module pht_step #(
   parameter int LEVEL_WIDTH = pht_pkg::DEF_LEVEL_WIDTH,
   parameter int TIME_WIDTH  = pht_pkg::DEF_TIME_WIDTH
) (
   input  wire logic [pht_pkg::MODE_WIDTH-1:0]     mode,
   input  wire logic [pht_pkg::DURATION_WIDTH-1:0] duration_limit,
   input  wire logic [LEVEL_WIDTH-1:0]             threshold,
   input  wire logic [LEVEL_WIDTH-1:0]             level,
   input  wire logic [pht_pkg::ELAPSED_WIDTH-1:0]  elapsed_units,
   input  wire logic [pht_pkg::PHASE_WIDTH-1:0]    phase_cur,
   input  wire logic                               prior_act,
   input  wire logic [TIME_WIDTH-1:0]              time_cur,
   output logic      [pht_pkg::PHASE_WIDTH-1:0]    phase_next,
   output logic                                    act_next,
   output logic      [TIME_WIDTH-1:0]              time_next,
   output pht_pkg::pht_event_type                  events
);

   localparam int CMP_WIDTH = (TIME_WIDTH > pht_pkg::DURATION_WIDTH) ?
                              TIME_WIDTH : pht_pkg::DURATION_WIDTH;
   localparam int DT_WIDTH  = (TIME_WIDTH < pht_pkg::ELAPSED_WIDTH) ?
                              TIME_WIDTH : pht_pkg::ELAPSED_WIDTH;

   logic                  cur;
   logic                  rise;
   logic                  fall;
   logic [TIME_WIDTH:0]   sum;
   logic [TIME_WIDTH-1:0] time_grown;
   logic [CMP_WIDTH-1:0]  limit_ext;

   assign cur  = level > threshold;
   assign rise = cur & ~prior_act;
   assign fall = ~cur & prior_act;

   // single saturating adder; growth only happens from started/performed
   assign sum = (TIME_WIDTH+1)'(time_cur) +
                (TIME_WIDTH+1)'(elapsed_units[DT_WIDTH-1:0]);
   assign time_grown = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
   assign limit_ext  = CMP_WIDTH'(duration_limit);
   assign act_next   = cur;

   always_comb begin
      logic [pht_pkg::PHASE_WIDTH-1:0] ph;
      logic [TIME_WIDTH-1:0]           t;
      logic [TIME_WIDTH-1:0]           t_hold;
      ph     = phase_cur;
      t      = time_cur;
      t_hold = (cur & prior_act) ? time_grown : time_cur;
      events = '0;
      unique case (mode)
         pht_pkg::MODE_PRESS: begin
            if (ph == pht_pkg::PH_CANCELED) begin
               ph = pht_pkg::PH_WAITING;
               t  = '0;
            end
            if (ph == pht_pkg::PH_WAITING) begin
               if (rise) begin
                  ph               = pht_pkg::PH_PERFORMED;
                  events.started   = 1'b1;
                  events.performed = 1'b1;
               end
            end else if (ph == pht_pkg::PH_PERFORMED) begin
               if (cur) t = time_grown;
               if (fall) begin
                  ph              = pht_pkg::PH_CANCELED;
                  events.canceled = 1'b1;
               end
            end
         end
         pht_pkg::MODE_HOLD: begin
            if (ph == pht_pkg::PH_CANCELED) begin
               ph = pht_pkg::PH_WAITING;
               t  = '0;
            end
            if (ph == pht_pkg::PH_WAITING) begin
               if (!cur) t = '0;
               if (rise) begin
                  ph             = pht_pkg::PH_STARTED;
                  events.started = 1'b1;
               end
            end else if (ph == pht_pkg::PH_STARTED) begin
               t = t_hold;
               if (CMP_WIDTH'(t_hold) >= limit_ext) begin
                  ph               = pht_pkg::PH_PERFORMED;
                  events.performed = 1'b1;
               end
               // release wins the phase even when the hold completed this tick
               if (fall) begin
                  ph              = pht_pkg::PH_CANCELED;
                  events.canceled = 1'b1;
               end
            end else if (ph == pht_pkg::PH_PERFORMED) begin
               if (cur) t = time_grown;
               if (fall) begin
                  ph              = pht_pkg::PH_CANCELED;
                  events.canceled = 1'b1;
               end
            end
         end
         pht_pkg::MODE_TAP: begin
            if (ph == pht_pkg::PH_PERFORMED || ph == pht_pkg::PH_CANCELED) begin
               ph = pht_pkg::PH_WAITING;
               t  = '0;
            end
            if (ph == pht_pkg::PH_WAITING) begin
               if (!cur) t = '0;
               if (rise) begin
                  ph             = pht_pkg::PH_STARTED;
                  events.started = 1'b1;
               end else if (fall) begin
                  ph              = pht_pkg::PH_CANCELED;
                  events.canceled = 1'b1;
               end
            end else if (ph == pht_pkg::PH_STARTED) begin
               if (cur) t = time_grown;
               if (fall) begin
                  // cur is low on a fall, so t is the unchanged time here
                  if (CMP_WIDTH'(time_cur) <= limit_ext) begin
                     ph               = pht_pkg::PH_PERFORMED;
                     events.performed = 1'b1;
                  end else begin
                     ph              = pht_pkg::PH_CANCELED;
                     events.canceled = 1'b1;
                  end
               end
            end
         end
         default: begin
            // no events, phase and time hold
         end
      endcase
      phase_next = ph;
      time_next  = t;
   end

endmodule
`default_nettype wire

// File: hw/rtl/press_hold_tap_detector.sv
// Pipeline: a word is taken into an input register, then its result is registered;
//   while rsp_valid is held without rsp_ready, the word waits in the input register.
// Throughput: one word per cycle while rsp_ready is high; the phase/time update is one
//   short combinational pass with a single saturating adder and a limit compare.
// Reset (synchronous, active high): phase waiting, time zero, not actuated,
//   all config registers zero, both pipeline stages empty.
`default_nettype none
`include "press_hold_tap_detector_defines.svh"
module press_hold_tap_detector #(
   parameter int LEVEL_WIDTH = pht_pkg::DEF_LEVEL_WIDTH,
   parameter int TIME_WIDTH  = pht_pkg::DEF_TIME_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [pht_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [pht_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [LEVEL_WIDTH-1:0]             req_level,
   input  wire logic [pht_pkg::ELAPSED_WIDTH-1:0]  req_elapsed_units,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_started_event,
   output logic                                    rsp_performed_event,
   output logic                                    rsp_canceled_event,
   output logic      [pht_pkg::PHASE_WIDTH-1:0]    rsp_phase_now,
   output logic      [pht_pkg::HELD_WIDTH-1:0]     rsp_held_time
);

   localparam int WIDE_WIDTH = (TIME_WIDTH > pht_pkg::HELD_WIDTH) ?
                               TIME_WIDTH : pht_pkg::HELD_WIDTH;

   // configuration
   logic [pht_pkg::MODE_WIDTH-1:0]     mode_ff;
   logic [pht_pkg::DURATION_WIDTH-1:0] limit_ff;
   logic [LEVEL_WIDTH-1:0]             thresh_ff;

   // input stage
   logic                              s1_valid_ff;
   logic [LEVEL_WIDTH-1:0]            s1_level_ff;
   logic [pht_pkg::ELAPSED_WIDTH-1:0] s1_elapsed_ff;

   // interaction state
   logic [pht_pkg::PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic                            act_ff, act_in;
   logic [TIME_WIDTH-1:0]           time_ff, time_in;

   // result register
   logic                            rsp_valid_ff;
   pht_pkg::pht_event_type          rsp_events_ff, events;
   logic [pht_pkg::PHASE_WIDTH-1:0] rsp_phase_ff;
   logic [pht_pkg::HELD_WIDTH-1:0]  rsp_held_ff;
   logic [WIDE_WIDTH-1:0]           time_wide;

   logic advance;

   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= pht_pkg::MODE_PRESS;
         limit_ff  <= '0;
         thresh_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            pht_pkg::REG_MODE:      mode_ff   <= csr_wdata[pht_pkg::MODE_WIDTH-1:0];
            pht_pkg::REG_DURATION:  limit_ff  <= csr_wdata[pht_pkg::DURATION_WIDTH-1:0];
            pht_pkg::REG_THRESHOLD: thresh_ff <= csr_wdata[LEVEL_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   pht_step #(
      .LEVEL_WIDTH (LEVEL_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_step (
      .mode           (mode_ff),
      .duration_limit (limit_ff),
      .threshold      (thresh_ff),
      .level          (s1_level_ff),
      .elapsed_units  (s1_elapsed_ff),
      .phase_cur      (phase_ff),
      .prior_act      (act_ff),
      .time_cur       (time_ff),
      .phase_next     (phase_in),
      .act_next       (act_in),
      .time_next      (time_in),
      .events         (events)
   );

   assign time_wide = WIDE_WIDTH'(time_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= pht_pkg::PH_WAITING;
         act_ff       <= 1'b0;
         time_ff      <= '0;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            act_ff       <= act_in;
            time_ff      <= time_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_level_ff   <= req_level;
         s1_elapsed_ff <= req_elapsed_units;
      end
      if (advance) begin
         rsp_events_ff <= events;
         rsp_phase_ff  <= phase_in;
         rsp_held_ff   <= time_wide[pht_pkg::HELD_WIDTH-1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_started_event   = rsp_events_ff.started;
   assign rsp_performed_event = rsp_events_ff.performed;
   assign rsp_canceled_event  = rsp_events_ff.canceled;
   assign rsp_phase_now       = rsp_phase_ff;
   assign rsp_held_time       = rsp_held_ff;

   `PHT_ASSERT_NOW(a_cancel_phase, clock, reset,
      rsp_valid_ff && rsp_events_ff.canceled, rsp_phase_ff == pht_pkg::PH_CANCELED)
   `PHT_ASSERT_NOW(a_perform_phase, clock, reset,
      rsp_valid_ff && rsp_events_ff.performed && !rsp_events_ff.canceled,
      rsp_phase_ff == pht_pkg::PH_PERFORMED)
   `PHT_ASSERT_NOW(a_press_pair, clock, reset,
      rsp_valid_ff && rsp_events_ff.started && rsp_events_ff.performed,
      rsp_phase_ff == pht_pkg::PH_PERFORMED)
   `PHT_ASSERT_NEXT(a_advance_fills, clock, reset, advance, rsp_valid_ff)
   `PHT_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && req_ready, s1_valid_ff)

endmodule
`default_nettype wire
